// File: src/llbp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command and status codes and types for the buffer placement block.
// Used by llbp_alu, the top level and the checker.
package llbp_pkg;

   localparam int NODE_COUNT   = 8;
   localparam int BUFFER_SLOTS = 32;
   localparam int NIDX_W       = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int SLOT_W       = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
   localparam int LOAD_W       = 48;
   localparam int ID_W         = 48;
   localparam int SIZE_W       = 32;
   localparam int TYPE_W       = 16;
   localparam int NODE_W       = 3;
   localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

   localparam logic [2:0] CMD_REG     = 3'd0;
   localparam logic [2:0] CMD_UNREG   = 3'd1;
   localparam logic [2:0] CMD_ALLOC   = 3'd2;
   localparam logic [2:0] CMD_FREE    = 3'd3;
   localparam logic [2:0] CMD_LOOKUP  = 3'd4;
   localparam logic [2:0] CMD_MIGRATE = 3'd5;
   localparam logic [2:0] CMD_EVAC    = 3'd6;
   localparam logic [2:0] CMD_READ    = 3'd7;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_NO_NODE   = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NO_IDS    = 3'd4;

   typedef struct packed {
      logic lt;
      logic eq;
   } alu_flags_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_NSCAN = 7'b0000010,
      S_PLACE = 7'b0000100,
      S_SSCAN = 7'b0001000,
      S_FOUND = 7'b0010000,
      S_SUB   = 7'b0100000,
      S_ADD   = 7'b1000000
   } state_type;

endpackage

// File: src/llbp_alu.sv
`timescale 1ns / 1ps
// Shared 48-bit compare and saturating add/subtract unit.
// Depends on llbp_pkg.
module llbp_alu (
   input  logic [llbp_pkg::LOAD_W-1:0] a,
   input  logic [llbp_pkg::LOAD_W-1:0] b,
   output llbp_pkg::alu_flags_type     flags,
   output logic [llbp_pkg::LOAD_W-1:0] add_sat,
   output logic [llbp_pkg::LOAD_W-1:0] sub_sat
);

   logic [llbp_pkg::LOAD_W:0] diff;
   logic [llbp_pkg::LOAD_W:0] sum;

   assign diff     = {1'b0, a} - {1'b0, b};
   assign sum      = {1'b0, a} + {1'b0, b};
   assign flags.lt = diff[llbp_pkg::LOAD_W];
   assign flags.eq = (a == b);
   // clamp at both ends
   assign sub_sat  = diff[llbp_pkg::LOAD_W] ? '0 : diff[llbp_pkg::LOAD_W-1:0];
   assign add_sat  = sum[llbp_pkg::LOAD_W] ? llbp_pkg::LOAD_MAX : sum[llbp_pkg::LOAD_W-1:0];

endmodule

// File: src/least_loaded_buffer_placement_top.sv
`timescale 1ns / 1ps
// Buffer placement table: sequencer, node and slot state, result registers.
// Depends on llbp_pkg and llbp_alu.
//
// Usage: drive a request on req_* and raise start while busy is low; the
// request is taken at that edge. Results appear on rsp_* for one cycle with
// rsp_strobe high; rsp_last marks the final result of a request. The receiver
// cannot stall, so each result must be taken in its strobe cycle.
// Register, unregister and read-bytes answer in the next cycle and never
// raise busy. Alloc scans the node counts, then places the buffer and adds
// its size to the chosen node. Free, lookup and migrate scan all slots;
// free and migrate then update the node loads. Evacuate first scans the
// node counts, then per moved buffer does one slot scan, one node scan and
// a subtract and an add update, and ends with a closing slot scan that
// finds nothing more.
// All scans and all load arithmetic share one compare/add/subtract unit.
// Busy drops in the cycle that shows the request's last result; an evacuate that moves nothing gives no result.
// Reset (synchronous) clears all node states, loads, slot use bits and sets
// the id counter to one; no clearing pass is needed.
module least_loaded_buffer_placement_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_cmd,
   input  logic [llbp_pkg::NODE_W-1:0]   req_node,
   input  logic                          req_pref_valid,
   input  logic [llbp_pkg::ID_W-1:0]     req_buf_id,
   input  logic [llbp_pkg::SIZE_W-1:0]   req_size_bytes,
   input  logic [llbp_pkg::TYPE_W-1:0]   req_elem_type,
   output logic                          rsp_strobe,
   output logic [2:0]                    rsp_status,
   output logic [llbp_pkg::ID_W-1:0]     rsp_out_id,
   output logic [llbp_pkg::NODE_W-1:0]   rsp_owner,
   output logic [llbp_pkg::SIZE_W-1:0]   rsp_out_size,
   output logic [llbp_pkg::TYPE_W-1:0]   rsp_out_type,
   output logic [llbp_pkg::LOAD_W-1:0]   rsp_load_bytes,
   output logic                          rsp_last
);

   localparam int NW = llbp_pkg::NIDX_W;
   localparam int SW = llbp_pkg::SLOT_W;
   localparam int LW = llbp_pkg::LOAD_W;
   localparam logic [NW-1:0] N_LAST = NW'(llbp_pkg::NODE_COUNT - 1);
   localparam logic [SW-1:0] S_LAST = SW'(llbp_pkg::BUFFER_SLOTS - 1);

   llbp_pkg::state_type state_ff;

   logic [llbp_pkg::NODE_COUNT-1:0]   node_live_ff;
   logic [LW-1:0]                     node_load_ff [llbp_pkg::NODE_COUNT];
   logic [llbp_pkg::BUFFER_SLOTS-1:0] slot_used_ff;
   logic [llbp_pkg::ID_W-1:0]         slot_id_ff    [llbp_pkg::BUFFER_SLOTS];
   logic [llbp_pkg::NODE_W-1:0]       slot_owner_ff [llbp_pkg::BUFFER_SLOTS];
   logic [llbp_pkg::SIZE_W-1:0]       slot_size_ff  [llbp_pkg::BUFFER_SLOTS];
   logic [llbp_pkg::TYPE_W-1:0]       slot_type_ff  [llbp_pkg::BUFFER_SLOTS];
   logic [llbp_pkg::ID_W-1:0]         next_id_ff;

   logic [2:0]                   cmd_ff;
   logic [llbp_pkg::NODE_W-1:0]  node_ff;
   logic                         pref_ff;
   logic [llbp_pkg::ID_W-1:0]    id_ff;
   logic [llbp_pkg::SIZE_W-1:0]  size_ff;
   logic [llbp_pkg::TYPE_W-1:0]  type_ff;

   logic [NW-1:0]                n_ff;
   logic [SW-1:0]                s_ff;
   logic                         skip_en_ff;
   logic                         best_found_ff;
   logic [NW-1:0]                best_ff;
   logic [LW-1:0]                best_load_ff;
   logic                         pick_found_ff;
   logic [SW-1:0]                pick_ff;
   logic [llbp_pkg::ID_W-1:0]    best_id_ff;
   logic                         evac_move_ff;
   logic                         pending_ff;
   logic                         add_pend_ff;
   logic [llbp_pkg::NODE_W-1:0]  sub_node_ff;
   logic [llbp_pkg::NODE_W-1:0]  add_node_ff;
   logic                         add_inr_ff;
   logic [llbp_pkg::SIZE_W-1:0]  amt_ff;

   logic                         rsp_strobe_ff;
   logic                         rsp_last_ff;
   logic [2:0]                   rsp_status_ff;
   logic [llbp_pkg::ID_W-1:0]    rsp_id_ff;
   logic [llbp_pkg::NODE_W-1:0]  rsp_owner_ff;
   logic [llbp_pkg::SIZE_W-1:0]  rsp_size_ff;
   logic [llbp_pkg::TYPE_W-1:0]  rsp_type_ff;
   logic [LW-1:0]                rsp_load_ff;

   logic [NW-1:0]                rd_idx;
   logic [LW-1:0]                ld_rd;
   logic [LW-1:0]                alu_a;
   logic [LW-1:0]                alu_b;
   llbp_pkg::alu_flags_type      flags;
   logic [LW-1:0]                add_sat;
   logic [LW-1:0]                sub_sat;
   logic                         free_any;
   logic [SW-1:0]                free_idx;
   logic                         req_inr;
   logic                         node_inr;
   logic [NW-1:0]                req_idx;
   logic [NW-1:0]                node_idx;
   logic                         find_mode;
   logic                         n_cand;
   logic                         s_cand;
   logic [llbp_pkg::NODE_W-1:0]  place_t;

   assign busy      = (state_ff != llbp_pkg::S_IDLE);
   assign req_inr   = (32'(req_node) < llbp_pkg::NODE_COUNT);
   assign node_inr  = (32'(node_ff) < llbp_pkg::NODE_COUNT);
   assign req_idx   = NW'(req_node);
   assign node_idx  = NW'(node_ff);
   assign find_mode = (cmd_ff != llbp_pkg::CMD_EVAC);

   // one read port on the node counts
   always_comb begin
      case (state_ff)
         llbp_pkg::S_IDLE: rd_idx = req_idx;
         llbp_pkg::S_SUB:  rd_idx = NW'(sub_node_ff);
         llbp_pkg::S_ADD:  rd_idx = NW'(add_node_ff);
         default:          rd_idx = n_ff;
      endcase
   end
   assign ld_rd = node_load_ff[rd_idx];

   always_comb begin
      case (state_ff)
         llbp_pkg::S_SSCAN: begin
            alu_a = slot_id_ff[s_ff];
            alu_b = find_mode ? id_ff : best_id_ff;
         end
         llbp_pkg::S_NSCAN: begin
            alu_a = ld_rd;
            alu_b = best_load_ff;
         end
         default: begin
            alu_a = ld_rd;
            alu_b = LW'(amt_ff);
         end
      endcase
   end

   llbp_alu u_alu (
      .a       (alu_a),
      .b       (alu_b),
      .flags   (flags),
      .add_sat (add_sat),
      .sub_sat (sub_sat)
   );

   // lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = llbp_pkg::BUFFER_SLOTS - 1; i >= 0; i--) begin
         if (!slot_used_ff[i]) begin
            free_any = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   assign n_cand = node_live_ff[n_ff] &&
                   !(skip_en_ff && (7'(n_ff) == 7'(node_ff)));
   assign s_cand = slot_used_ff[s_ff] &&
                   (find_mode ? flags.eq
                              : ((slot_owner_ff[s_ff] == node_ff) &&
                                 (!pick_found_ff || flags.lt)));
   assign place_t = (pref_ff && node_inr && node_live_ff[node_idx]) ?
                    node_ff : llbp_pkg::NODE_W'(best_ff);

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= llbp_pkg::S_IDLE;
         node_live_ff  <= '0;
         for (int i = 0; i < llbp_pkg::NODE_COUNT; i++) node_load_ff[i] <= '0;
         slot_used_ff  <= '0;
         next_id_ff    <= llbp_pkg::ID_W'(1);
         rsp_strobe_ff <= 1'b0;
         pending_ff    <= 1'b0;
         evac_move_ff  <= 1'b0;
      end else begin
         case (state_ff)
            llbp_pkg::S_IDLE: begin
               rsp_strobe_ff <= start && (req_cmd == llbp_pkg::CMD_REG ||
                                          req_cmd == llbp_pkg::CMD_UNREG ||
                                          req_cmd == llbp_pkg::CMD_READ);
               if (start) begin
                  case (req_cmd)
                     llbp_pkg::CMD_REG: begin
                        if (req_inr && !node_live_ff[req_idx]) begin
                           node_live_ff[req_idx] <= 1'b1;
                           node_load_ff[req_idx] <= '0;
                        end
                     end
                     llbp_pkg::CMD_UNREG: begin
                        if (req_inr) begin
                           node_live_ff[req_idx] <= 1'b0;
                           node_load_ff[req_idx] <= '0;
                        end
                     end
                     llbp_pkg::CMD_READ: begin
                     end
                     llbp_pkg::CMD_ALLOC, llbp_pkg::CMD_EVAC: begin
                        state_ff     <= llbp_pkg::S_NSCAN;
                        evac_move_ff <= 1'b0;
                        pending_ff   <= 1'b0;
                     end
                     default: state_ff <= llbp_pkg::S_SSCAN;
                  endcase
               end
            end
            llbp_pkg::S_NSCAN: begin
               rsp_strobe_ff <= 1'b0;
               if (n_ff == N_LAST) state_ff <= llbp_pkg::S_PLACE;
            end
            llbp_pkg::S_PLACE: begin
               rsp_strobe_ff <= (cmd_ff == llbp_pkg::CMD_ALLOC) &&
                                (!best_found_ff || !free_any || next_id_ff == '0);
               if (cmd_ff == llbp_pkg::CMD_ALLOC) begin
                  if (!best_found_ff || !free_any || next_id_ff == '0) begin
                     state_ff <= llbp_pkg::S_IDLE;
                  end else begin
                     slot_used_ff[free_idx] <= 1'b1;
                     next_id_ff             <= next_id_ff + 1'b1;
                     state_ff               <= llbp_pkg::S_ADD;
                  end
               end else if (!evac_move_ff) begin
                  state_ff <= best_found_ff ? llbp_pkg::S_SSCAN : llbp_pkg::S_IDLE;
               end else begin
                  pending_ff <= 1'b1;
                  state_ff   <= llbp_pkg::S_SUB;
               end
            end
            llbp_pkg::S_SSCAN: begin
               rsp_strobe_ff <= 1'b0;
               if (s_ff == S_LAST) state_ff <= llbp_pkg::S_FOUND;
            end
            llbp_pkg::S_FOUND: begin
               // a pending move goes out now that we know whether another follows
               rsp_strobe_ff <= find_mode ?
                                (!pick_found_ff || cmd_ff == llbp_pkg::CMD_LOOKUP) :
                                pending_ff;
               if (find_mode) begin
                  if (!pick_found_ff || cmd_ff == llbp_pkg::CMD_LOOKUP) begin
                     state_ff <= llbp_pkg::S_IDLE;
                  end else begin
                     if (cmd_ff == llbp_pkg::CMD_FREE) slot_used_ff[pick_ff] <= 1'b0;
                     state_ff <= llbp_pkg::S_SUB;
                  end
               end else begin
                  pending_ff   <= 1'b0;
                  evac_move_ff <= 1'b1;
                  state_ff <= pick_found_ff ? llbp_pkg::S_NSCAN : llbp_pkg::S_IDLE;
               end
            end
            llbp_pkg::S_SUB: begin
               rsp_strobe_ff <= !add_pend_ff;
               if (node_live_ff[NW'(sub_node_ff)] &&
                   32'(sub_node_ff) < llbp_pkg::NODE_COUNT)
                  node_load_ff[NW'(sub_node_ff)] <= sub_sat;
               state_ff <= add_pend_ff ? llbp_pkg::S_ADD : llbp_pkg::S_IDLE;
            end
            llbp_pkg::S_ADD: begin
               rsp_strobe_ff <= (cmd_ff != llbp_pkg::CMD_EVAC);
               if (add_inr_ff && node_live_ff[NW'(add_node_ff)])
                  node_load_ff[NW'(add_node_ff)] <= add_sat;
               state_ff <= (cmd_ff == llbp_pkg::CMD_EVAC) ? llbp_pkg::S_SSCAN
                                                          : llbp_pkg::S_IDLE;
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= llbp_pkg::S_IDLE;
            end
         endcase
      end
   end

   // datapath and payload registers
   always_ff @(posedge clock) begin
      case (state_ff)
         llbp_pkg::S_IDLE: begin
            cmd_ff        <= req_cmd;
            node_ff       <= req_node;
            pref_ff       <= req_pref_valid;
            id_ff         <= req_buf_id;
            size_ff       <= req_size_bytes;
            type_ff       <= req_elem_type;
            n_ff          <= '0;
            s_ff          <= '0;
            best_found_ff <= 1'b0;
            pick_found_ff <= 1'b0;
            skip_en_ff    <= (req_cmd == llbp_pkg::CMD_EVAC);
            rsp_id_ff     <= '0;
            rsp_owner_ff  <= '0;
            rsp_size_ff   <= '0;
            rsp_type_ff   <= '0;
            rsp_last_ff   <= 1'b1;
            rsp_status_ff <= ((req_cmd == llbp_pkg::CMD_REG ||
                               req_cmd == llbp_pkg::CMD_UNREG) && !req_inr) ?
                             llbp_pkg::ST_NOT_FOUND : llbp_pkg::ST_OK;
            rsp_load_ff   <= (req_cmd == llbp_pkg::CMD_READ && req_inr &&
                              node_live_ff[req_idx]) ? ld_rd : '0;
         end
         llbp_pkg::S_NSCAN: begin
            if (n_cand && (!best_found_ff || flags.lt)) begin
               best_found_ff <= 1'b1;
               best_ff       <= n_ff;
               best_load_ff  <= ld_rd;
            end
            n_ff <= n_ff + 1'b1;
         end
         llbp_pkg::S_PLACE: begin
            rsp_load_ff <= '0;
            if (cmd_ff == llbp_pkg::CMD_ALLOC) begin
               rsp_last_ff <= 1'b1;
               if (!best_found_ff)     rsp_status_ff <= llbp_pkg::ST_NO_NODE;
               else if (!free_any)     rsp_status_ff <= llbp_pkg::ST_FULL;
               else if (next_id_ff == '0) rsp_status_ff <= llbp_pkg::ST_NO_IDS;
               else begin
                  rsp_status_ff           <= llbp_pkg::ST_OK;
                  rsp_id_ff               <= next_id_ff;
                  rsp_owner_ff            <= place_t;
                  rsp_size_ff             <= size_ff;
                  rsp_type_ff             <= type_ff;
                  slot_id_ff[free_idx]    <= next_id_ff;
                  slot_owner_ff[free_idx] <= place_t;
                  slot_size_ff[free_idx]  <= size_ff;
                  slot_type_ff[free_idx]  <= type_ff;
                  add_node_ff             <= place_t;
                  add_inr_ff              <= 1'b1;
                  amt_ff                  <= size_ff;
               end
            end else begin
               s_ff          <= '0;
               pick_found_ff <= 1'b0;
               if (evac_move_ff) begin
                  rsp_status_ff          <= llbp_pkg::ST_OK;
                  rsp_id_ff              <= slot_id_ff[pick_ff];
                  rsp_owner_ff           <= llbp_pkg::NODE_W'(best_ff);
                  rsp_size_ff            <= slot_size_ff[pick_ff];
                  rsp_type_ff            <= slot_type_ff[pick_ff];
                  slot_owner_ff[pick_ff] <= llbp_pkg::NODE_W'(best_ff);
                  sub_node_ff            <= node_ff;
                  add_node_ff            <= llbp_pkg::NODE_W'(best_ff);
                  add_inr_ff             <= 1'b1;
                  add_pend_ff            <= 1'b1;
                  amt_ff                 <= slot_size_ff[pick_ff];
               end
            end
         end
         llbp_pkg::S_SSCAN: begin
            if (s_cand && !(find_mode && pick_found_ff)) begin
               pick_found_ff <= 1'b1;
               pick_ff       <= s_ff;
               best_id_ff    <= slot_id_ff[s_ff];
            end
            s_ff <= s_ff + 1'b1;
         end
         llbp_pkg::S_FOUND: begin
            n_ff          <= '0;
            best_found_ff <= 1'b0;
            rsp_last_ff   <= find_mode ? 1'b1 : !pick_found_ff;
            if (find_mode) begin
               if (!pick_found_ff) begin
                  rsp_status_ff <= llbp_pkg::ST_NOT_FOUND;
               end else begin
                  rsp_status_ff <= llbp_pkg::ST_OK;
                  rsp_id_ff     <= slot_id_ff[pick_ff];
                  rsp_size_ff   <= slot_size_ff[pick_ff];
                  rsp_type_ff   <= slot_type_ff[pick_ff];
                  rsp_owner_ff  <= (cmd_ff == llbp_pkg::CMD_MIGRATE) ?
                                   node_ff : slot_owner_ff[pick_ff];
                  sub_node_ff   <= slot_owner_ff[pick_ff];
                  amt_ff        <= slot_size_ff[pick_ff];
                  add_node_ff   <= node_ff;
                  add_inr_ff    <= node_inr;
                  add_pend_ff   <= (cmd_ff == llbp_pkg::CMD_MIGRATE);
                  if (cmd_ff == llbp_pkg::CMD_MIGRATE)
                     slot_owner_ff[pick_ff] <= node_ff;
               end
            end
         end
         llbp_pkg::S_ADD: begin
            s_ff          <= '0;
            pick_found_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_id     = rsp_id_ff;
   assign rsp_owner      = rsp_owner_ff;
   assign rsp_out_size   = rsp_size_ff;
   assign rsp_out_type   = rsp_type_ff;
   assign rsp_load_bytes = rsp_load_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: src/llbp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the buffer placement block, bound to the top level.
// Depends on llbp_pkg and least_loaded_buffer_placement_top.
module llbp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic [2:0]                  rsp_status,
   input logic [llbp_pkg::ID_W-1:0]   rsp_out_id,
   input logic [llbp_pkg::LOAD_W-1:0] rsp_load_bytes,
   input logic                        rsp_last
);

   // only evacuate moves give results that are not last, and those succeed
   a_nonlast_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> rsp_status == llbp_pkg::ST_OK)
      else $error("failed result not marked last");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("busy or strobe after reset");

   a_fail_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != llbp_pkg::ST_OK |-> rsp_out_id == '0 && rsp_last)
      else $error("failed request carries an id");

   a_load_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_load_bytes != '0 |-> rsp_last && rsp_out_id == '0)
      else $error("byte count on a non read result");

endmodule

bind least_loaded_buffer_placement_top llbp_checker u_llbp_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_status     (rsp_status),
   .rsp_out_id     (rsp_out_id),
   .rsp_load_bytes (rsp_load_bytes),
   .rsp_last       (rsp_last)
);
